[rtl/hsre_pkg.sv]
// Shared types, constants and helper functions of the heating step-response estimator.
// Used by hsre_div and heating_step_response_estimator_core; depends on nothing else.
package hsre_pkg;

   localparam int RING_DEPTH        = 10;
   localparam int RING_IDX_W        = $clog2(RING_DEPTH);
   localparam int RING_CNT_W        = $clog2(RING_DEPTH + 1);
   localparam int HEAT_RATE_SAMPLES = 10;
   localparam int HEAT_CNT_W        = 4;

   // Shared divider: unsigned dividend and divisor widths.
   localparam int DVD_W     = 56;
   localparam int DVS_W     = 40;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // Median keys are all fields widened to one signed width.
   localparam int KEY_W = 33;

   localparam int MIN_DT_MS         = 500;
   localparam int RATE_MIN          = 1678;
   localparam int HEAT_RATE_DEFAULT = 16777;
   localparam int COOL_RATE_DEFAULT = 8389;
   localparam int ONE_DEGC          = 256;
   localparam int DRIVE_MIN         = 25;
   localparam int TAU_HEAT_DEFAULT  = 3600;
   localparam int TAU_MIN           = 300;
   localparam int TAU_HEAT_MAX      = 36000;
   localparam int TAU_COOL_MAX      = 72000;
   localparam int GAIN_MAX          = 65535;
   localparam int STABLE_MAX        = 255;
   localparam logic [23:0] COOL_COUNT_MAX = 24'hFFFFFF;
   localparam logic [31:0] RATE_SAT       = 32'hFFFF_FFFF;

   localparam logic [11:0] SETTLE_BAND_RST   = 12'd77;
   localparam logic [11:0] MIN_RISE_RST      = 12'd51;
   localparam logic [7:0]  SETTLE_NEEDED_RST = 8'd5;

   typedef enum logic [1:0] {
      CSR_SETTLE_BAND   = 2'd0,
      CSR_MIN_RISE      = 2'd1,
      CSR_SETTLE_NEEDED = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_HEAT   = 2'd1,
      PHASE_SETTLE = 2'd2
   } phase_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EVAL = 6'b000010,
      ST_LOAD = 6'b000100,
      ST_WAIT = 6'b001000,
      ST_MED  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      OP_COOL = 4'd0,
      OP_HEAT = 4'd1,
      OP_GAIN = 4'd2,
      OP_HAVG = 4'd3,
      OP_TAUH = 4'd4,
      OP_CAVG = 4'd5,
      OP_TAUC = 4'd6,
      OP_RING = 4'd7,
      OP_MED  = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      MF_GAIN = 3'd0,
      MF_TAUH = 3'd1,
      MF_TAUC = 3'd2,
      MF_DEAD = 3'd3,
      MF_OUTS = 3'd4
   } field_type;

   // First outstanding arithmetic step of an item.
   function automatic op_type first_op(input logic cool, input logic heat, input logic fin);
      op_type r;
      if (cool) r = OP_COOL;
      else if (heat) r = OP_HEAT;
      else if (fin) r = OP_GAIN;
      else r = OP_MED;
      return r;
   endfunction

   function automatic logic [16:0] abs17(input logic signed [16:0] v);
      return v[16] ? 17'(-v) : 17'(v);
   endfunction

   function automatic logic [39:0] abs40(input logic signed [39:0] v);
      return v[39] ? 40'(-v) : 40'(v);
   endfunction

   // Q8.8 difference times 65536000, the scale that gives 2^-24 degC/s over ms.
   function automatic logic [DVD_W-1:0] scale_rate(input logic [16:0] m);
      logic [DVD_W-1:0] e;
      e = {{(DVD_W-17){1'b0}}, m};
      return (e << 26) - (e << 20) - (e << 19);
   endfunction

   function automatic logic [16:0] clamp17(input logic signed [56:0] v,
                                           input logic [16:0] lo, input logic [16:0] hi);
      logic [16:0] r;
      if (v < $signed({40'b0, lo})) r = lo;
      else if (v > $signed({40'b0, hi})) r = hi;
      else r = v[16:0];
      return r;
   endfunction

endpackage

[rtl/hsre_div.sv]
// Restoring unsigned divider, one quotient bit per cycle, shared by all divisions.
// Depends on hsre_pkg for the operand widths.
module hsre_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hsre_pkg::DVD_W-1:0]     dividend,
   input  logic [hsre_pkg::DVS_W-1:0]     divisor,
   output logic                           done,
   output logic [hsre_pkg::DVD_W-1:0]     quotient
);

   logic                             run_ff;
   logic                             done_ff;
   logic [hsre_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [hsre_pkg::DVS_W-1:0]       rem_ff;
   logic [hsre_pkg::DVS_W-1:0]       dvs_ff;
   logic [hsre_pkg::DVD_W-1:0]       quo_ff;
   logic [hsre_pkg::DVS_W:0]         trial;
   logic [hsre_pkg::DVS_W:0]         diff;
   logic                             fits;
   logic [hsre_pkg::DVS_W-1:0]       rem_in;

   assign trial  = {rem_ff, quo_ff[hsre_pkg::DVD_W-1]};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign diff   = trial - {1'b0, dvs_ff};
   assign rem_in = fits ? diff[hsre_pkg::DVS_W-1:0] : trial[hsre_pkg::DVS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= hsre_pkg::DIV_CNT_W'(hsre_pkg::DVD_W - 1);
         end else if (run_ff) begin
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // The dividend shifts out at the top while quotient bits shift in below.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[hsre_pkg::DVD_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/heating_step_response_estimator_core.sv]
// Heating step-response estimator: phase machine, event parameters and ring medians.
// Depends on hsre_pkg and hsre_div.
//
// Use: each beat on the req_ channel is one heating sample (action 0) or a clear
// (action 1). Every accepted beat yields exactly one beat on the rsp_ channel with
// the medians over the event ring, the number of stored events and the phase.
// req_stall is high while an item is being worked on; the block takes one item
// at a time. Each division goes through the shared 56-step divider, a sample can need
// two rate divisions, a settled event five more, and the medians visit every stored
// event once for each of the five fields.
// A finished result waits in the output register while rsp_stall is high; the
// next item may still be accepted, and its result is held back until the
// previous beat has been taken.
// The csr_ channel writes the settle band, the minimum rise and the settle count
// and is always ready; it is meant to be written while the block is idle.
// A synchronous reset empties the ring, returns to the idle phase and restores
// the register defaults; rsp_valid is low after reset.
module heating_step_response_estimator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic signed [15:0] req_room_temp,
   input  logic signed [15:0] req_target_temp,
   input  logic               req_flame_on,
   input  logic               req_hot_water_active,
   input  logic signed [15:0] req_outside_temp,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_gain_median,
   output logic [15:0]        rsp_tau_heat_median_s,
   output logic [16:0]        rsp_tau_cool_median_s,
   output logic [31:0]        rsp_dead_time_median_ms,
   output logic signed [15:0] rsp_outside_typical,
   output logic [3:0]         rsp_events_stored,
   output logic [1:0]         rsp_phase,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   localparam int RW = hsre_pkg::RING_IDX_W;
   localparam int CW = hsre_pkg::RING_CNT_W;
   localparam int KW = hsre_pkg::KEY_W;

   hsre_pkg::state_type state_ff;
   hsre_pkg::op_type    op_ff;
   hsre_pkg::phase_type phase_ff;
   hsre_pkg::field_type fld_ff;

   logic               in_action_ff, in_flame_ff, in_hw_ff;
   logic signed [15:0] in_room_ff, in_target_ff, in_outside_ff;
   logic [31:0]        in_now_ff;

   logic [11:0] band_ff, min_rise_ff;
   logic [7:0]  needed_ff;

   logic               last_flame_ff, last_hw_ff, rise_seen_ff;
   logic signed [15:0] last_room_ff, start_room_ff, setpoint_ff, peak_ff;
   logic [31:0]        last_time_ff, flame_start_ff, first_rise_ff;
   logic signed [39:0] heat_sum_ff;
   logic [hsre_pkg::HEAT_CNT_W-1:0] heat_cnt_ff;
   logic [55:0]        cool_sum_ff;
   logic [23:0]        cool_cnt_ff;
   logic [7:0]         stable_ff;

   logic               need_cool_ff, need_heat_ff, need_fin_ff, neg_ff;
   logic signed [16:0] rdiff_ff, num_ff;
   logic [31:0]        dt_ff;
   logic [15:0]        gain_ff, tauh_ff;
   logic [16:0]        tauc_ff;
   logic signed [40:0] avg_ff;

   logic [15:0]        ring_gain [hsre_pkg::RING_DEPTH];
   logic [15:0]        ring_tauh [hsre_pkg::RING_DEPTH];
   logic [16:0]        ring_tauc [hsre_pkg::RING_DEPTH];
   logic [31:0]        ring_dead [hsre_pkg::RING_DEPTH];
   logic signed [15:0] ring_outs [hsre_pkg::RING_DEPTH];
   logic [RW-1:0]      head_ff;
   logic [CW-1:0]      count_ff;

   logic [RW-1:0]        idx_ff;
   logic signed [KW-1:0] lo_ff, hi_ff;
   logic signed [KW-1:0] med_gain_ff, med_tauh_ff, med_tauc_ff, med_dead_ff, med_outs_ff;

   logic               rsp_valid_ff;
   logic [15:0]        rsp_gain_ff, rsp_tauh_ff;
   logic [16:0]        rsp_tauc_ff;
   logic [31:0]        rsp_dead_ff;
   logic signed [15:0] rsp_outs_ff;
   logic [3:0]         rsp_events_ff;
   logic [1:0]         rsp_phase_ff;

   // ---------------------------------------------------------------- sample evaluation
   logic [31:0]        dt_w;
   logic signed [16:0] room17, last17, tgt17, start17, peak17, set17, out17;
   logic signed [16:0] rdiff_w, rise_w, drv_w, err_w;
   logic signed [17:0] room18, tgt_lo_w, err18, nerr18, band18, out_hi_w;
   logic signed [18:0] rise4_w, drv19_w;
   logic               start_ev, rise_hit, heat_ok, in_band, fin_w, cool_pre;
   logic [7:0]         stable_inc, stable_new;

   always_comb begin
      dt_w     = in_now_ff - last_time_ff;
      room17   = {in_room_ff[15], in_room_ff};
      last17   = {last_room_ff[15], last_room_ff};
      tgt17    = {in_target_ff[15], in_target_ff};
      start17  = {start_room_ff[15], start_room_ff};
      peak17   = {peak_ff[15], peak_ff};
      set17    = {setpoint_ff[15], setpoint_ff};
      out17    = {in_outside_ff[15], in_outside_ff};
      rdiff_w  = room17 - last17;
      rise_w   = room17 - start17;
      drv_w    = tgt17 - start17;
      err_w    = room17 - tgt17;
      room18   = {room17[16], room17};
      band18   = $signed({6'b0, band_ff});
      tgt_lo_w = $signed({tgt17[16], tgt17}) - band18;
      err18    = {err_w[16], err_w};
      nerr18   = -err18;
      out_hi_w = $signed({out17[16], out17}) + 18'(hsre_pkg::ONE_DEGC);
      rise4_w  = $signed({rise_w, 2'b00});
      drv19_w  = {{2{drv_w[16]}}, drv_w};
      start_ev = in_flame_ff && !last_flame_ff && (room18 < tgt_lo_w);
      rise_hit = !rise_seen_ff && (rise_w > $signed({5'b0, min_rise_ff}));
      heat_ok  = (heat_cnt_ff < hsre_pkg::HEAT_CNT_W'(hsre_pkg::HEAT_RATE_SAMPLES))
                 && (rise4_w < drv19_w);
      in_band  = (err18 <= band18) && (nerr18 <= band18);
      stable_inc = (stable_ff == 8'(hsre_pkg::STABLE_MAX)) ? stable_ff : stable_ff + 8'd1;
      stable_new = in_band ? stable_inc : 8'd0;
      fin_w      = stable_new >= needed_ff;
      cool_pre   = !in_flame_ff && rdiff_w[16] && (room18 > out_hi_w)
                   && (cool_cnt_ff != hsre_pkg::COOL_COUNT_MAX);
   end

   // ---------------------------------------------------------------- divider operands
   logic signed [16:0] rise_f, drive_f, delta_f;
   logic               div_go, div_neg, div_done;
   logic [hsre_pkg::DVD_W-1:0] dvd, quo;
   logic [hsre_pkg::DVS_W-1:0] dvs;
   logic signed [56:0] sq;
   logic               avg_ok;

   assign rise_f  = peak17 - start17;
   assign drive_f = set17 - start17;
   assign delta_f = peak17 - out17;
   assign avg_ok  = avg_ff >= 41'(hsre_pkg::RATE_MIN);
   assign sq      = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   always_comb begin
      div_go  = 1'b0;
      div_neg = 1'b0;
      dvd     = '0;
      dvs     = '0;
      if (state_ff == hsre_pkg::ST_LOAD) begin
         unique case (op_ff)
            hsre_pkg::OP_COOL: begin
               div_go = 1'b1;
               dvd    = hsre_pkg::scale_rate(hsre_pkg::abs17(rdiff_ff));
               dvs    = {8'b0, dt_ff};
            end
            hsre_pkg::OP_HEAT: begin
               div_go  = 1'b1;
               div_neg = rdiff_ff[16];
               dvd     = hsre_pkg::scale_rate(hsre_pkg::abs17(rdiff_ff));
               dvs     = {8'b0, dt_ff};
            end
            hsre_pkg::OP_GAIN: begin
               if (drive_f > 17'sd25) begin
                  div_go  = 1'b1;
                  div_neg = rise_f[16];
                  dvd     = {31'b0, hsre_pkg::abs17(rise_f), 8'b0};
                  dvs     = {23'b0, drive_f};
               end
            end
            hsre_pkg::OP_HAVG: begin
               if (heat_cnt_ff != '0) begin
                  div_go  = 1'b1;
                  div_neg = heat_sum_ff[39];
                  dvd     = {16'b0, hsre_pkg::abs40(heat_sum_ff)};
                  dvs     = {36'b0, heat_cnt_ff};
               end
            end
            hsre_pkg::OP_TAUH: begin
               if (avg_ok && (num_ff > 17'sd0)) begin
                  div_go = 1'b1;
                  dvd    = {23'b0, num_ff, 16'b0};
                  dvs    = avg_ff[39:0];
               end
            end
            hsre_pkg::OP_CAVG: begin
               if (cool_cnt_ff != '0) begin
                  div_go = 1'b1;
                  dvd    = cool_sum_ff;
                  dvs    = {16'b0, cool_cnt_ff};
               end
            end
            hsre_pkg::OP_TAUC: begin
               if (avg_ok && (delta_f > 17'sd256)) begin
                  div_go = 1'b1;
                  dvd    = {23'b0, delta_f, 16'b0};
                  dvs    = avg_ff[39:0];
               end
            end
            default: begin
               div_go = 1'b0;
            end
         endcase
      end
   end

   hsre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );

   hsre_pkg::op_type next_op;

   always_comb begin
      unique case (op_ff)
         hsre_pkg::OP_COOL: next_op = hsre_pkg::first_op(1'b0, need_heat_ff, need_fin_ff);
         hsre_pkg::OP_HEAT: next_op = hsre_pkg::first_op(1'b0, 1'b0, need_fin_ff);
         hsre_pkg::OP_GAIN: next_op = hsre_pkg::OP_HAVG;
         hsre_pkg::OP_HAVG: next_op = hsre_pkg::OP_TAUH;
         hsre_pkg::OP_TAUH: next_op = hsre_pkg::OP_CAVG;
         hsre_pkg::OP_CAVG: next_op = hsre_pkg::OP_TAUC;
         hsre_pkg::OP_TAUC: next_op = hsre_pkg::OP_RING;
         default:           next_op = hsre_pkg::OP_MED;
      endcase
   end

   // ---------------------------------------------------------------- median by rank
   logic signed [KW-1:0] keys [hsre_pkg::RING_DEPTH];
   logic signed [KW-1:0] cand, lo_in, hi_in;
   logic signed [KW:0]   med_sum;
   logic [CW:0]          less_w, eq_w, k_lo, k_hi;
   logic                 last_idx;

   always_comb begin
      for (int j = 0; j < hsre_pkg::RING_DEPTH; j++) begin
         unique case (fld_ff)
            hsre_pkg::MF_GAIN: keys[j] = $signed({17'b0, ring_gain[j]});
            hsre_pkg::MF_TAUH: keys[j] = $signed({17'b0, ring_tauh[j]});
            hsre_pkg::MF_TAUC: keys[j] = $signed({16'b0, ring_tauc[j]});
            hsre_pkg::MF_DEAD: keys[j] = $signed({1'b0, ring_dead[j]});
            default:           keys[j] = {{17{ring_outs[j][15]}}, ring_outs[j]};
         endcase
      end
      cand   = keys[idx_ff];
      less_w = '0;
      eq_w   = '0;
      for (int j = 0; j < hsre_pkg::RING_DEPTH; j++) begin
         if (CW'(j) < count_ff) begin
            less_w = less_w + {{CW{1'b0}}, keys[j] < cand};
            eq_w   = eq_w + {{CW{1'b0}}, keys[j] == cand};
         end
      end
      k_lo     = {1'b0, count_ff - 1'b1} >> 1;
      k_hi     = {1'b0, count_ff} >> 1;
      lo_in    = ((less_w <= k_lo) && (k_lo < less_w + eq_w)) ? cand : lo_ff;
      hi_in    = ((less_w <= k_hi) && (k_hi < less_w + eq_w)) ? cand : hi_ff;
      // Floor of the mean of the two middle values; for an odd count both are the same.
      med_sum  = {lo_in[KW-1], lo_in} + {hi_in[KW-1], hi_in};
      last_idx = ({1'b0, idx_ff} == {1'b0, count_ff} - 1'b1);
   end

   // ---------------------------------------------------------------- sequencer and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hsre_pkg::ST_IDLE;
         op_ff         <= hsre_pkg::OP_MED;
         phase_ff      <= hsre_pkg::PHASE_IDLE;
         band_ff       <= hsre_pkg::SETTLE_BAND_RST;
         min_rise_ff   <= hsre_pkg::MIN_RISE_RST;
         needed_ff     <= hsre_pkg::SETTLE_NEEDED_RST;
         last_flame_ff <= 1'b0;
         last_hw_ff    <= 1'b0;
         rise_seen_ff  <= 1'b0;
         last_room_ff  <= '0;
         start_room_ff <= '0;
         setpoint_ff   <= '0;
         peak_ff       <= '0;
         last_time_ff  <= '0;
         flame_start_ff <= '0;
         first_rise_ff <= '0;
         heat_sum_ff   <= '0;
         heat_cnt_ff   <= '0;
         cool_sum_ff   <= '0;
         cool_cnt_ff   <= '0;
         stable_ff     <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               hsre_pkg::CSR_SETTLE_BAND:   band_ff     <= csr_wdata;
               hsre_pkg::CSR_MIN_RISE:      min_rise_ff <= csr_wdata;
               hsre_pkg::CSR_SETTLE_NEEDED: needed_ff   <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            hsre_pkg::ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= hsre_pkg::ST_EVAL;
               end
            end

            hsre_pkg::ST_EVAL: begin
               state_ff     <= hsre_pkg::ST_LOAD;
               op_ff        <= hsre_pkg::OP_MED;
               need_cool_ff <= 1'b0;
               need_heat_ff <= 1'b0;
               need_fin_ff  <= 1'b0;
               rdiff_ff     <= rdiff_w;
               dt_ff        <= dt_w;
               if (in_action_ff) begin
                  phase_ff      <= hsre_pkg::PHASE_IDLE;
                  head_ff       <= '0;
                  count_ff      <= '0;
                  last_flame_ff <= 1'b0;
                  last_hw_ff    <= 1'b0;
                  last_time_ff  <= in_now_ff;
               end else if (in_hw_ff) begin
                  if (!last_hw_ff) phase_ff <= hsre_pkg::PHASE_IDLE;
                  last_flame_ff <= in_flame_ff;
                  last_hw_ff    <= 1'b1;
                  last_room_ff  <= in_room_ff;
                  last_time_ff  <= in_now_ff;
               end else if (dt_w >= 32'(hsre_pkg::MIN_DT_MS)) begin
                  unique case (phase_ff)
                     hsre_pkg::PHASE_IDLE: begin
                        if (start_ev) begin
                           start_room_ff  <= in_room_ff;
                           setpoint_ff    <= in_target_ff;
                           flame_start_ff <= in_now_ff;
                           first_rise_ff  <= '0;
                           rise_seen_ff   <= 1'b0;
                           peak_ff        <= in_room_ff;
                           heat_sum_ff    <= '0;
                           heat_cnt_ff    <= '0;
                           cool_sum_ff    <= '0;
                           cool_cnt_ff    <= '0;
                           phase_ff       <= hsre_pkg::PHASE_HEAT;
                        end
                     end
                     hsre_pkg::PHASE_HEAT: begin
                        if (rise_hit) begin
                           first_rise_ff <= in_now_ff;
                           rise_seen_ff  <= 1'b1;
                        end
                        if (in_room_ff > peak_ff) peak_ff <= in_room_ff;
                        need_heat_ff <= heat_ok;
                        if (!in_flame_ff && last_flame_ff) begin
                           phase_ff <= hsre_pkg::PHASE_IDLE;
                        end else if (room18 >= tgt_lo_w) begin
                           stable_ff <= 8'd1;
                           phase_ff  <= hsre_pkg::PHASE_SETTLE;
                        end
                     end
                     default: begin
                        if (in_room_ff > peak_ff) peak_ff <= in_room_ff;
                        stable_ff   <= stable_new;
                        need_fin_ff <= fin_w;
                        if (fin_w) begin
                           phase_ff <= hsre_pkg::PHASE_IDLE;
                        end else if ((room18 < tgt_lo_w) && in_flame_ff) begin
                           phase_ff <= hsre_pkg::PHASE_HEAT;
                        end
                     end
                  endcase
                  need_cool_ff  <= cool_pre;
                  op_ff         <= hsre_pkg::first_op(cool_pre,
                                      (phase_ff == hsre_pkg::PHASE_HEAT) && heat_ok,
                                      (phase_ff == hsre_pkg::PHASE_SETTLE) && fin_w);
                  last_flame_ff <= in_flame_ff;
                  last_hw_ff    <= 1'b0;
                  last_room_ff  <= in_room_ff;
                  last_time_ff  <= in_now_ff;
               end
            end

            hsre_pkg::ST_LOAD: begin
               if (div_go) begin
                  neg_ff   <= div_neg;
                  state_ff <= hsre_pkg::ST_WAIT;
                  if (op_ff == hsre_pkg::OP_GAIN) num_ff <= rise_f;
               end else begin
                  op_ff <= next_op;
                  unique case (op_ff)
                     hsre_pkg::OP_GAIN: begin
                        gain_ff <= 16'(hsre_pkg::ONE_DEGC);
                        num_ff  <= drive_f;
                     end
                     hsre_pkg::OP_HAVG: avg_ff <= 41'(hsre_pkg::HEAT_RATE_DEFAULT);
                     hsre_pkg::OP_TAUH: begin
                        tauh_ff <= avg_ok ? 16'(hsre_pkg::TAU_MIN)
                                          : 16'(hsre_pkg::TAU_HEAT_DEFAULT);
                     end
                     hsre_pkg::OP_CAVG: avg_ff <= 41'(hsre_pkg::COOL_RATE_DEFAULT);
                     hsre_pkg::OP_TAUC: begin
                        tauc_ff <= 17'(({2'b0, tauh_ff} + {1'b0, tauh_ff, 1'b0}) >> 1);
                     end
                     hsre_pkg::OP_RING: begin
                        ring_gain[head_ff] <= gain_ff;
                        ring_tauh[head_ff] <= tauh_ff;
                        ring_tauc[head_ff] <= tauc_ff;
                        ring_dead[head_ff] <= rise_seen_ff ? first_rise_ff - flame_start_ff
                                                           : 32'd0;
                        ring_outs[head_ff] <= in_outside_ff;
                        head_ff <= (head_ff == RW'(hsre_pkg::RING_DEPTH - 1)) ? '0
                                   : head_ff + 1'b1;
                        if (count_ff != CW'(hsre_pkg::RING_DEPTH)) count_ff <= count_ff + 1'b1;
                     end
                     hsre_pkg::OP_MED: begin
                        fld_ff <= hsre_pkg::MF_GAIN;
                        idx_ff <= '0;
                        if (count_ff == '0) begin
                           med_gain_ff <= '0;
                           med_tauh_ff <= '0;
                           med_tauc_ff <= '0;
                           med_dead_ff <= '0;
                           med_outs_ff <= '0;
                           state_ff    <= hsre_pkg::ST_OUT;
                        end else begin
                           state_ff <= hsre_pkg::ST_MED;
                        end
                     end
                     default: ;
                  endcase
               end
            end

            hsre_pkg::ST_WAIT: begin
               if (div_done) begin
                  op_ff    <= next_op;
                  state_ff <= hsre_pkg::ST_LOAD;
                  unique case (op_ff)
                     hsre_pkg::OP_COOL: begin
                        if (sq >= 57'(hsre_pkg::RATE_MIN)) begin
                           cool_sum_ff <= cool_sum_ff + {24'b0,
                              (sq > $signed({25'b0, hsre_pkg::RATE_SAT})) ? hsre_pkg::RATE_SAT
                                                                          : sq[31:0]};
                           cool_cnt_ff <= cool_cnt_ff + 24'd1;
                        end
                     end
                     hsre_pkg::OP_HEAT: begin
                        heat_sum_ff <= heat_sum_ff + $signed(sq[39:0]);
                        heat_cnt_ff <= heat_cnt_ff + 1'b1;
                     end
                     hsre_pkg::OP_GAIN: begin
                        gain_ff <= 16'(hsre_pkg::clamp17(sq, 17'd0, 17'(hsre_pkg::GAIN_MAX)));
                     end
                     hsre_pkg::OP_TAUH: begin
                        tauh_ff <= 16'(hsre_pkg::clamp17(sq, 17'(hsre_pkg::TAU_MIN),
                                                         17'(hsre_pkg::TAU_HEAT_MAX)));
                     end
                     hsre_pkg::OP_TAUC: begin
                        tauc_ff <= hsre_pkg::clamp17(sq, 17'(hsre_pkg::TAU_MIN),
                                                     17'(hsre_pkg::TAU_COOL_MAX));
                     end
                     default: avg_ff <= sq[40:0];
                  endcase
               end
            end

            hsre_pkg::ST_MED: begin
               lo_ff <= lo_in;
               hi_ff <= hi_in;
               if (last_idx) begin
                  idx_ff <= '0;
                  unique case (fld_ff)
                     hsre_pkg::MF_GAIN: begin
                        med_gain_ff <= med_sum[KW:1];
                        fld_ff      <= hsre_pkg::MF_TAUH;
                     end
                     hsre_pkg::MF_TAUH: begin
                        med_tauh_ff <= med_sum[KW:1];
                        fld_ff      <= hsre_pkg::MF_TAUC;
                     end
                     hsre_pkg::MF_TAUC: begin
                        med_tauc_ff <= med_sum[KW:1];
                        fld_ff      <= hsre_pkg::MF_DEAD;
                     end
                     hsre_pkg::MF_DEAD: begin
                        med_dead_ff <= med_sum[KW:1];
                        fld_ff      <= hsre_pkg::MF_OUTS;
                     end
                     default: begin
                        med_outs_ff <= med_sum[KW:1];
                        state_ff    <= hsre_pkg::ST_OUT;
                     end
                  endcase
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end

            default: begin
               // Hand the result over once the output register is free.
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= hsre_pkg::ST_IDLE;
               end
            end
         endcase
      end
   end

   // Input capture and result register payload.
   always_ff @(posedge clock) begin
      if (state_ff == hsre_pkg::ST_IDLE && req_valid) begin
         in_action_ff  <= req_action;
         in_room_ff    <= req_room_temp;
         in_target_ff  <= req_target_temp;
         in_flame_ff   <= req_flame_on;
         in_hw_ff      <= req_hot_water_active;
         in_outside_ff <= req_outside_temp;
         in_now_ff     <= req_now_ms;
      end
      if (state_ff == hsre_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_gain_ff   <= med_gain_ff[15:0];
         rsp_tauh_ff   <= med_tauh_ff[15:0];
         rsp_tauc_ff   <= med_tauc_ff[16:0];
         rsp_dead_ff   <= med_dead_ff[31:0];
         rsp_outs_ff   <= med_outs_ff[15:0];
         rsp_events_ff <= 4'(count_ff);
         rsp_phase_ff  <= phase_ff;
      end
   end

   assign req_stall               = (state_ff != hsre_pkg::ST_IDLE);
   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_gain_median         = rsp_gain_ff;
   assign rsp_tau_heat_median_s   = rsp_tauh_ff;
   assign rsp_tau_cool_median_s   = rsp_tauc_ff;
   assign rsp_dead_time_median_ms = rsp_dead_ff;
   assign rsp_outside_typical     = rsp_outs_ff;
   assign rsp_events_stored       = rsp_events_ff;
   assign rsp_phase               = rsp_phase_ff;

endmodule
